// ===== rtl/core/opuc_pkg.sv =====
// ----------------------------------------------------------------------------
// Offset-point unicycle controller package
// Shared types, widths, register indexes and constant tables.
// ----------------------------------------------------------------------------
package opuc_pkg;

  localparam int FRAC_BITS         = 16;
  localparam int ANGLE_BITS        = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int CORDIC_MAX        = 24;

  // Internal widths.
  localparam int EW   = 34;             // target minus relative position
  localparam int CW   = 37;             // rotator datapath with growth
  localparam int ZW   = 33;             // rotator angle accumulator
  localparam int XW   = 38;             // robot frame errors after offset
  localparam int SUMW = 39;             // offset plus forward error
  localparam int DW   = 39;             // divisor width
  localparam int NW   = 31 + FRAC_BITS; // dividend and quotient width
  localparam int QW   = 48;             // operand and product width
  localparam int GW   = 24;             // rotator gain fraction bits

  localparam logic [GW-1:0]   ROT_GAIN    = 24'd10188014;
  localparam logic [QW-2:0]   INTER_LIMIT = '1;

  localparam logic [2:0] CFG_TARGET_X        = 3'd0;
  localparam logic [2:0] CFG_TARGET_Y        = 3'd1;
  localparam logic [2:0] CFG_GAIN_LINEAR     = 3'd2;
  localparam logic [2:0] CFG_GAIN_LATERAL    = 3'd3;
  localparam logic [2:0] CFG_INVERSE_SHAPING = 3'd4;
  localparam logic [2:0] CFG_OFFSET_D        = 3'd5;

  localparam logic signed [31:0] ATAN_TAB [CORDIC_MAX] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81
  };

  typedef struct packed {
    logic signed [31:0]           pose_x;
    logic signed [31:0]           pose_y;
    logic signed [ANGLE_BITS-1:0] heading;
  } in_t;

  typedef struct packed {
    logic signed [31:0] linear_cmd;
    logic signed [31:0] angular_cmd;
  } out_t;

  typedef struct packed {
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic [30:0]        gain_linear;
    logic [30:0]        gain_lateral;
    logic [30:0]        inverse_shaping;
    logic [30:0]        offset_d;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [QW:0] v);
    logic signed [31:0] r;
    if (v > (QW+1)'(32'sh7FFFFFFF)) begin
      r = 32'sh7FFFFFFF;
    end else if (v < (QW+1)'(-33'sd2147483648)) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/opuc_front.sv =====
// ----------------------------------------------------------------------------
// Front end
// Captures the origin, forms the target error and pre-rotates by a half turn
// when the rotation angle lies outside the rotator's convergence range.
// ----------------------------------------------------------------------------
module opuc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_fire,
  input  opuc_pkg::in_t                 in_data,
  input  opuc_pkg::cfg_t                cfg,
  output logic                          v_o,
  output logic signed [opuc_pkg::CW-1:0] x_o,
  output logic signed [opuc_pkg::CW-1:0] y_o,
  output logic signed [opuc_pkg::ZW-1:0] z_o
);
  import opuc_pkg::*;

  logic                         org_v_r;
  logic signed [31:0]           org_x_r, org_y_r;
  logic                         v1_r, v2_r;
  logic signed [EW-1:0]         ex1_r, ey1_r, ex_nxt, ey_nxt;
  logic signed [ANGLE_BITS-1:0] h1_r;
  logic signed [31:0]           ox, oy;
  logic signed [32:0]           relx, rely;
  logic [31:0]                  zr, zf;
  logic                         flip;
  logic signed [CW-1:0]         x2_r, y2_r;
  logic signed [ZW-1:0]         z2_r;

  // The first sample after reset is its own origin.
  assign ox     = org_v_r ? org_x_r : in_data.pose_x;
  assign oy     = org_v_r ? org_y_r : in_data.pose_y;
  assign relx   = 33'(in_data.pose_x) - 33'(ox);
  assign rely   = 33'(in_data.pose_y) - 33'(oy);
  assign ex_nxt = EW'(cfg.target_x) - EW'(relx);
  assign ey_nxt = EW'(cfg.target_y) - EW'(rely);

  assign zr   = 32'd0 - {h1_r, {(32-ANGLE_BITS){1'b0}}};
  assign flip = zr[30] ^ zr[31];
  assign zf   = {zr[31] ^ flip, zr[30:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_v_r <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
    end else if (en) begin
      v1_r <= in_fire;
      v2_r <= v1_r;
      if (in_fire && !org_v_r) begin
        org_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_fire && !org_v_r) begin
      org_x_r <= in_data.pose_x;
      org_y_r <= in_data.pose_y;
    end
    if (en) begin
      ex1_r <= ex_nxt;
      ey1_r <= ey_nxt;
      h1_r  <= in_data.heading;
      x2_r  <= flip ? -CW'(ex1_r) : CW'(ex1_r);
      y2_r  <= flip ? -CW'(ey1_r) : CW'(ey1_r);
      z2_r  <= ZW'($signed(zf));
    end
  end

  assign v_o = v2_r;
  assign x_o = x2_r;
  assign y_o = y2_r;
  assign z_o = z2_r;

endmodule

// ===== rtl/core/opuc_cordic.sv =====
// ----------------------------------------------------------------------------
// Rotator
// Pipelined CORDIC rotation, one stage per iteration, followed by the gain
// correction multiply and the look-ahead offset.
// ----------------------------------------------------------------------------
module opuc_cordic #(
  parameter int STAGES = opuc_pkg::CORDIC_STAGES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           v_i,
  input  logic signed [opuc_pkg::CW-1:0] x_i,
  input  logic signed [opuc_pkg::CW-1:0] y_i,
  input  logic signed [opuc_pkg::ZW-1:0] z_i,
  input  opuc_pkg::cfg_t                 cfg,
  output logic                           v_o,
  output logic signed [opuc_pkg::XW-1:0] xn_o,
  output logic signed [opuc_pkg::XW-1:0] yn_o
);
  import opuc_pkg::*;

  localparam int MW = CW + GW + 1;

  logic                 v_s [STAGES+1];
  logic signed [CW-1:0] x_s [STAGES+1];
  logic signed [CW-1:0] y_s [STAGES+1];
  logic signed [ZW-1:0] z_s [STAGES+1];
  logic                 vm_r, vn_r;
  logic signed [MW-1:0] mx_r, my_r;
  logic signed [XW-1:0] xn_r, yn_r;

  assign v_s[0] = v_i;
  assign x_s[0] = x_i;
  assign y_s[0] = y_i;
  assign z_s[0] = z_i;

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic                 v_r;
    logic signed [CW-1:0] x_r, y_r;
    logic signed [ZW-1:0] z_r;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v_s[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_s[k][ZW-1]) begin
          x_r <= x_s[k] - (y_s[k] >>> k);
          y_r <= y_s[k] + (x_s[k] >>> k);
          z_r <= z_s[k] - ZW'(ATAN_TAB[k]);
        end else begin
          x_r <= x_s[k] + (y_s[k] >>> k);
          y_r <= y_s[k] - (x_s[k] >>> k);
          z_r <= z_s[k] + ZW'(ATAN_TAB[k]);
        end
      end
    end
    assign v_s[k+1] = v_r;
    assign x_s[k+1] = x_r;
    assign y_s[k+1] = y_r;
    assign z_s[k+1] = z_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
      vn_r <= 1'b0;
    end else if (en) begin
      vm_r <= v_s[STAGES];
      vn_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx_r <= MW'(x_s[STAGES]) * MW'($signed({1'b0, ROT_GAIN}));
      my_r <= MW'(y_s[STAGES]) * MW'($signed({1'b0, ROT_GAIN}));
      xn_r <= XW'(mx_r >>> GW) - XW'($signed({1'b0, cfg.offset_d}));
      yn_r <= XW'(my_r >>> GW);
    end
  end

  assign v_o  = vn_r;
  assign xn_o = xn_r;
  assign yn_o = yn_r;

endmodule

// ===== rtl/core/opuc_div.sv =====
// ----------------------------------------------------------------------------
// Gain dividers
// Two restoring dividers side by side, one quotient bit per stage, that form
// k * 2^FRAC_BITS / (inverse_shaping + |error|) for both errors.
// ----------------------------------------------------------------------------
module opuc_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           v_i,
  input  logic signed [opuc_pkg::XW-1:0] xn_i,
  input  logic signed [opuc_pkg::XW-1:0] yn_i,
  input  opuc_pkg::cfg_t                 cfg,
  output logic                           v_o,
  output logic [opuc_pkg::NW-1:0]        t1_o,
  output logic [opuc_pkg::NW-1:0]        t2_o,
  output logic signed [opuc_pkg::XW-1:0] xn_o,
  output logic signed [opuc_pkg::XW-1:0] yn_o
);
  import opuc_pkg::*;

  typedef struct packed {
    logic                 v;
    logic [DW-1:0]        rem1;
    logic [DW-1:0]        rem2;
    logic [NW-1:0]        nq1;
    logic [NW-1:0]        nq2;
    logic [DW-1:0]        den1;
    logic [DW-1:0]        den2;
    logic signed [XW-1:0] xn;
    logic signed [XW-1:0] yn;
  } div_row_t;

  div_row_t      row [NW+1];
  logic [XW-1:0] magx, magy;
  logic [DW-1:0] sumx, sumy;

  assign magx = xn_i[XW-1] ? XW'(-xn_i) : XW'(xn_i);
  assign magy = yn_i[XW-1] ? XW'(-yn_i) : XW'(yn_i);
  assign sumx = DW'(cfg.inverse_shaping) + DW'(magx);
  assign sumy = DW'(cfg.inverse_shaping) + DW'(magy);

  // Setup stage: divisors, with a zero divisor taken as one LSB.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row[0].v <= 1'b0;
    end else if (en) begin
      row[0].v <= v_i;
    end
    if (en) begin
      row[0].rem1 <= '0;
      row[0].rem2 <= '0;
      row[0].nq1  <= {cfg.gain_linear, {FRAC_BITS{1'b0}}};
      row[0].nq2  <= {cfg.gain_lateral, {FRAC_BITS{1'b0}}};
      row[0].den1 <= (sumx == '0) ? DW'(1) : sumx;
      row[0].den2 <= (sumy == '0) ? DW'(1) : sumy;
      row[0].xn   <= xn_i;
      row[0].yn   <= yn_i;
    end
  end

  // The dividend shifts out of the top of nq while quotient bits enter below.
  for (genvar k = 0; k < NW; k++) begin : g_step
    logic [DW:0] sh1, sh2;
    logic        ge1, ge2;
    assign sh1 = {row[k].rem1, row[k].nq1[NW-1]};
    assign sh2 = {row[k].rem2, row[k].nq2[NW-1]};
    assign ge1 = sh1 >= {1'b0, row[k].den1};
    assign ge2 = sh2 >= {1'b0, row[k].den2};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        row[k+1].v <= 1'b0;
      end else if (en) begin
        row[k+1].v <= row[k].v;
      end
      if (en) begin
        row[k+1].rem1 <= ge1 ? DW'(sh1 - {1'b0, row[k].den1}) : DW'(sh1);
        row[k+1].rem2 <= ge2 ? DW'(sh2 - {1'b0, row[k].den2}) : DW'(sh2);
        row[k+1].nq1  <= {row[k].nq1[NW-2:0], ge1};
        row[k+1].nq2  <= {row[k].nq2[NW-2:0], ge2};
        row[k+1].den1 <= row[k].den1;
        row[k+1].den2 <= row[k].den2;
        row[k+1].xn   <= row[k].xn;
        row[k+1].yn   <= row[k].yn;
      end
    end
  end

  assign v_o  = row[NW].v;
  assign t1_o = row[NW].nq1;
  assign t2_o = row[NW].nq2;
  assign xn_o = row[NW].xn;
  assign yn_o = row[NW].yn;

endmodule

// ===== rtl/core/opuc_qmul.sv =====
// ----------------------------------------------------------------------------
// Fixed-point multiplier
// Four-stage signed Q multiply: magnitudes, 24 by 24 partial products,
// their sum, then floor scaling with the magnitude saturated to 2^47-1.
// ----------------------------------------------------------------------------
module opuc_qmul #(
  parameter int SBW = 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           v_i,
  input  logic signed [opuc_pkg::QW-1:0] a_i,
  input  logic signed [opuc_pkg::QW-1:0] b_i,
  input  logic [SBW-1:0]                 sb_i,
  output logic                           v_o,
  output logic signed [opuc_pkg::QW-1:0] p_o,
  output logic [SBW-1:0]                 sb_o
);
  import opuc_pkg::*;

  localparam int HW = QW / 2;
  localparam int PW = 2 * QW;
  localparam int FW = PW - FRAC_BITS + 1;

  logic [3:0]      v_r;
  logic [SBW-1:0]  sb_r [4];
  logic [3:0]      neg_r;
  logic [QW-1:0]   ma_r, mb_r;
  logic [QW-1:0]   pll_r, plh_r, phl_r, phh_r;
  logic [PW-1:0]   prod_r;
  logic [FW-1:0]   qf;
  logic [QW-2:0]   qm;
  logic signed [QW-1:0] p_r;

  // Negative products round toward minus infinity.
  assign qf = FW'(prod_r >> FRAC_BITS) + FW'(neg_r[2] && (prod_r[FRAC_BITS-1:0] != '0));
  assign qm = (qf > FW'(INTER_LIMIT)) ? INTER_LIMIT : qf[QW-2:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], v_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= sb_i;
      sb_r[1] <= sb_r[0];
      sb_r[2] <= sb_r[1];
      sb_r[3] <= sb_r[2];
      neg_r   <= {neg_r[2:0], a_i[QW-1] ^ b_i[QW-1]};
      ma_r    <= a_i[QW-1] ? QW'(-a_i) : QW'(a_i);
      mb_r    <= b_i[QW-1] ? QW'(-b_i) : QW'(b_i);
      pll_r   <= ma_r[HW-1:0]  * mb_r[HW-1:0];
      plh_r   <= ma_r[HW-1:0]  * mb_r[QW-1:HW];
      phl_r   <= ma_r[QW-1:HW] * mb_r[HW-1:0];
      phh_r   <= ma_r[QW-1:HW] * mb_r[QW-1:HW];
      prod_r  <= PW'(pll_r) + (PW'(plh_r) << HW) + (PW'(phl_r) << HW)
                 + (PW'(phh_r) << QW);
      p_r     <= neg_r[2] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
    end
  end

  assign v_o  = v_r[3];
  assign p_o  = p_r;
  assign sb_o = sb_r[3];

endmodule

// ===== rtl/core/offset_point_unicycle_controller.sv =====
// ----------------------------------------------------------------------------
// Offset-point unicycle position controller
// Turns pose samples into saturated linear and angular velocity commands.
//
//   Channel  Handshake                   Payload
//   in       in_valid / in_ready         in_data  (pose_x, pose_y, heading)
//   out      out_valid / out_ready       out_data (linear_cmd, angular_cmd)
//   cfg      cfg_we                      cfg_index, cfg_data
//
// One sample enters per cycle while the pipeline is not held. A sample passes
// through the front end, the rotator stages, the one-bit-per-stage dividers
// and three chained four-stage multipliers.
// Reset clears valid bits and the origin and loads the register defaults; the
// first sample after reset becomes the origin. A stalled output parks one
// result in a skid register and the whole pipeline holds until it drains.
// ----------------------------------------------------------------------------
module offset_point_unicycle_controller #(
  parameter int CORDIC_STAGES = opuc_pkg::CORDIC_STAGES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  opuc_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output opuc_pkg::out_t  out_data,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [31:0]     cfg_data
);
  import opuc_pkg::*;

  cfg_t cfg_r;
  logic en, in_fire, out_fire;

  logic                 f_v, c_v, d_v, a1_v, a2_v, b_v, m_v;
  logic signed [CW-1:0] f_x, f_y;
  logic signed [ZW-1:0] f_z;
  logic signed [XW-1:0] c_xn, c_yn, d_xn, d_yn, a1_yn, b_yn;
  logic [NW-1:0]        t1, t2;
  logic signed [SUMW-1:0] s_sum;
  logic [SUMW-1:0]      a2_s;
  logic signed [QW-1:0] term1, u, w, term2, b_term1, m_term1, m_w;
  logic [XW-1:0]        a1_sb;
  out_t                 res;
  out_t                 out_r, out_nxt, skid_r, skid_nxt;
  logic                 out_v_r, out_v_nxt, skid_v_r, skid_v_nxt;

  assign en       = !skid_v_r;
  assign in_ready = en;
  assign in_fire  = in_valid && en;
  assign out_fire = out_v_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_x        <= '0;
      cfg_r.target_y        <= '0;
      cfg_r.gain_linear     <= 31'(1) << FRAC_BITS;
      cfg_r.gain_lateral    <= 31'(1) << FRAC_BITS;
      cfg_r.inverse_shaping <= 31'(1) << FRAC_BITS;
      cfg_r.offset_d        <= 31'(1) << (FRAC_BITS - 2);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET_X:        cfg_r.target_x        <= cfg_data;
        CFG_TARGET_Y:        cfg_r.target_y        <= cfg_data;
        CFG_GAIN_LINEAR:     cfg_r.gain_linear     <= cfg_data[30:0];
        CFG_GAIN_LATERAL:    cfg_r.gain_lateral    <= cfg_data[30:0];
        CFG_INVERSE_SHAPING: cfg_r.inverse_shaping <= cfg_data[30:0];
        CFG_OFFSET_D:        cfg_r.offset_d        <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  opuc_front u_front (
    .clk, .rst_n, .en, .in_fire, .in_data, .cfg(cfg_r),
    .v_o(f_v), .x_o(f_x), .y_o(f_y), .z_o(f_z)
  );

  opuc_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
    .clk, .rst_n, .en, .v_i(f_v), .x_i(f_x), .y_i(f_y), .z_i(f_z), .cfg(cfg_r),
    .v_o(c_v), .xn_o(c_xn), .yn_o(c_yn)
  );

  opuc_div u_div (
    .clk, .rst_n, .en, .v_i(c_v), .xn_i(c_xn), .yn_i(c_yn), .cfg(cfg_r),
    .v_o(d_v), .t1_o(t1), .t2_o(t2), .xn_o(d_xn), .yn_o(d_yn)
  );

  assign s_sum = SUMW'($signed({1'b0, cfg_r.offset_d})) + SUMW'(d_xn);

  // term1 = t1 * xn, carrying yn alongside.
  opuc_qmul #(.SBW(XW)) u_mul_t1 (
    .clk, .rst_n, .en, .v_i(d_v), .a_i(QW'(t1)), .b_i(QW'(d_xn)), .sb_i(d_yn),
    .v_o(a1_v), .p_o(term1), .sb_o(a1_sb)
  );

  // u = t2 * yn, carrying offset plus forward error alongside.
  opuc_qmul #(.SBW(SUMW)) u_mul_u (
    .clk, .rst_n, .en, .v_i(d_v), .a_i(QW'(t2)), .b_i(QW'(d_yn)), .sb_i(s_sum),
    .v_o(a2_v), .p_o(u), .sb_o(a2_s)
  );

  assign a1_yn = $signed(a1_sb);

  opuc_qmul #(.SBW(QW + XW)) u_mul_w (
    .clk, .rst_n, .en, .v_i(a1_v && a2_v), .a_i(u), .b_i(QW'($signed(a2_s))),
    .sb_i({term1, a1_yn}),
    .v_o(b_v), .p_o(w), .sb_o({b_term1, b_yn})
  );

  opuc_qmul #(.SBW(2 * QW)) u_mul_t2 (
    .clk, .rst_n, .en, .v_i(b_v), .a_i(w), .b_i(QW'(b_yn)), .sb_i({b_term1, w}),
    .v_o(m_v), .p_o(term2), .sb_o({m_term1, m_w})
  );

  assign res.linear_cmd  = sat32((QW+1)'(m_term1) + (QW+1)'(term2));
  assign res.angular_cmd = sat32((QW+1)'(m_w));

  // The pipeline's last item moves whenever en is high; it lands in the
  // output register or, when that one is held, in the skid register.
  always_comb begin
    out_nxt    = out_r;
    out_v_nxt  = out_v_r;
    skid_nxt   = skid_r;
    skid_v_nxt = skid_v_r;
    if (skid_v_r) begin
      if (out_fire) begin
        out_nxt    = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (m_v) begin
      if (!out_v_r || out_fire) begin
        out_nxt   = res;
        out_v_nxt = 1'b1;
      end else begin
        skid_nxt   = res;
        skid_v_nxt = 1'b1;
      end
    end else if (out_fire) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/core/opuc_checker.sv =====
// ----------------------------------------------------------------------------
// Port checker
// Watches the controller's ports for handshake and back-pressure slips.
// ----------------------------------------------------------------------------
module opuc_port_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input opuc_pkg::in_t   in_data,
  input logic            out_valid,
  input logic            out_ready,
  input opuc_pkg::out_t  out_data
);

  // A held result keeps its value until the transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A refused pose sample stays offered and unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input sample changed while stalled");

  // Input back-pressure only ever comes from a waiting result.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

  a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("input stalled without a refused transfer");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not empty after reset");

endmodule

bind offset_point_unicycle_controller opuc_port_checker u_opuc_checker (.*);

// ===== tb/opuc_checker.sv =====
// ----------------------------------------------------------------------------
// Offset-point unicycle controller checker
// Mirrors configuration writes, predicts each command pair from accepted pose
// samples and compares the accepted results against the oldest prediction.
// ----------------------------------------------------------------------------
module opuc_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  opuc_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  opuc_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [31:0]    cfg_data,
  output int             fail_count,
  output int             pending_count,
  output int             cmd_count
);
  import opuc_pkg::*;

  localparam longint LIMIT47 = 64'h7FFF_FFFF_FFFF;

  cfg_t           regs;
  logic           have_origin;
  longint         org_x, org_y;
  out_t           cmd_queue[$];

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  // Product of two Q values with floor rounding and magnitude clamp at 2^47-1.
  function automatic longint qprod(longint a, longint b);
    logic signed [127:0] p;
    logic signed [127:0] q;
    p = 128'(signed'(a)) * 128'(signed'(b));
    q = p >>> FRAC_BITS;
    if (q > 128'(LIMIT47)) return LIMIT47;
    if (q < -128'(LIMIT47)) return -LIMIT47;
    return longint'(q);
  endfunction

  function automatic longint shaped_gain(longint k, longint err);
    longint den;
    den = longint'(regs.inverse_shaping) + (err < 0 ? -err : err);
    if (den == 0) den = 1;
    return (k <<< FRAC_BITS) / den;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic out_t predict_cmd(in_t s);
    longint ex, ey, zs, dx, dy, xn, yn, t1, t2, u, w, term1, term2;
    logic [31:0] z;
    out_t r;
    ex = longint'(regs.target_x) - (longint'(s.pose_x) - org_x);
    ey = longint'(regs.target_y) - (longint'(s.pose_y) - org_y);
    z = 32'(0) - {s.heading, 16'h0};
    // Angles in the back half plane are handled by a half-turn first.
    if (z[30] ^ z[31]) begin
      ex = -ex;
      ey = -ey;
      z[31] = ~z[31];
    end
    zs = longint'(signed'(z));
    for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
      dx = floor_shift(ey, i);
      dy = floor_shift(ex, i);
      if (zs >= 0) begin
        ex -= dx; ey += dy; zs -= longint'(ATAN_TAB[i]);
      end else begin
        ex += dx; ey -= dy; zs += longint'(ATAN_TAB[i]);
      end
    end
    xn = floor_shift(ex * longint'(ROT_GAIN), GW) - longint'(regs.offset_d);
    yn = floor_shift(ey * longint'(ROT_GAIN), GW);
    t1 = shaped_gain(longint'(regs.gain_linear), xn);
    t2 = shaped_gain(longint'(regs.gain_lateral), yn);
    term1 = qprod(t1, xn);
    u = qprod(t2, yn);
    w = qprod(u, longint'(regs.offset_d) + xn);
    term2 = qprod(w, yn);
    r.linear_cmd = 32'(clamp32(term1 + term2));
    r.angular_cmd = 32'(clamp32(w));
    return r;
  endfunction

  assign pending_count = cmd_queue.size();

  always @(posedge clk) begin
    out_t exp_cmd;
    if (!rst_n) begin
      regs.target_x <= '0;
      regs.target_y <= '0;
      regs.gain_linear <= 31'd65536;
      regs.gain_lateral <= 31'd65536;
      regs.inverse_shaping <= 31'd65536;
      regs.offset_d <= 31'd16384;
      have_origin <= 1'b0;
      org_x = 0;
      org_y = 0;
      fail_count <= 0;
      cmd_count <= 0;
      cmd_queue.delete();
    end else begin
      if (out_valid && out_ready) begin
        cmd_count <= cmd_count + 1;
        if (cmd_queue.size() == 0) begin
          $error("unexpected result transfer: %h", out_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_cmd = cmd_queue.pop_front();
          if (out_data.linear_cmd !== exp_cmd.linear_cmd) begin
            $error("linear_cmd: expected %0d, got %0d", exp_cmd.linear_cmd,
                   out_data.linear_cmd);
            fail_count <= fail_count + 1;
          end
          if (out_data.angular_cmd !== exp_cmd.angular_cmd) begin
            $error("angular_cmd: expected %0d, got %0d", exp_cmd.angular_cmd,
                   out_data.angular_cmd);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        // The first sample after reset becomes the origin.
        if (!have_origin) begin
          org_x = longint'(in_data.pose_x);
          org_y = longint'(in_data.pose_y);
          have_origin <= 1'b1;
        end
        cmd_queue.push_back(predict_cmd(in_data));
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_TARGET_X:        regs.target_x <= cfg_data;
          CFG_TARGET_Y:        regs.target_y <= cfg_data;
          CFG_GAIN_LINEAR:     regs.gain_linear <= cfg_data[30:0];
          CFG_GAIN_LATERAL:    regs.gain_lateral <= cfg_data[30:0];
          CFG_INVERSE_SHAPING: regs.inverse_shaping <= cfg_data[30:0];
          CFG_OFFSET_D:        regs.offset_d <= cfg_data[30:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Offset-point unicycle controller testbench
// Drives pose samples in bursts through several register settings, stalls the
// command side, and lets the checker compare every command pair.
// ----------------------------------------------------------------------------
module tb;
  import opuc_pkg::*;

  localparam int LATENCY = 80;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_ready;
  in_t   in_data;
  logic  out_valid;
  logic  out_ready;
  out_t  out_data;
  logic  cfg_we;
  logic  [2:0] cfg_index;
  logic  [31:0] cfg_data;
  int    fail_count;
  int    pending_count;
  int    cmd_count;
  int    sample_count;
  int    hold_cycles;

  offset_point_unicycle_controller u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  opuc_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count),
    .cmd_count(cmd_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("FAIL");
    $finish;
  end

  // Receiver: random stall pattern, a long hold-off when requested.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles = hold_cycles - 1;
      end else if (($urandom & 255) < 8) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic send_sample(input in_t s);
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sample_count++;
    @(negedge clk);
  endtask

  task automatic idle_sender(input int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  // Each write is followed by a pause with cfg_we low on the write port.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick32(input logic [31:0] mask);
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF & mask;
      1: return {$urandom} & mask;
      2: return $urandom_range(0, 1 << 18) & mask;
      3: return 32'($urandom_range(0, 1 << 20)) - 32'h80000;
      4: return 32'h80000000 & mask;
      default: return $urandom_range(1, 1 << 17) & mask;
    endcase
  endfunction

  function automatic in_t rand_sample(input int mode);
    in_t s;
    s.heading = 16'($urandom);
    if (mode == 0) begin
      s.pose_x = $urandom;
      s.pose_y = $urandom;
    end else begin
      s.pose_x = 32'($urandom_range(0, 1 << 22)) - 32'h200000;
      s.pose_y = 32'($urandom_range(0, 1 << 22)) - 32'h200000;
    end
    return s;
  endfunction

  task automatic random_burst(input int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && n > 0) begin
        send_sample(rand_sample($urandom_range(0, 3) == 0 ? 0 : 1));
        burst--;
        n--;
      end
      if ($urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 12));
    end
  endtask

  initial begin
    in_t s;
    logic signed [15:0] hd [8] = '{16'sh0000, 16'sh4000, 16'shC000, 16'sh7FFF,
                                   16'sh8000, 16'sh3FFF, 16'sh4001, 16'sh2000};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_TARGET_X;
    cfg_data = '0;
    sample_count = 0;
    hold_cycles = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: origin capture at a far corner, then field extremes and
    // headings around the half-turn boundaries.
    s.pose_x = 32'sh7FFFFFFF; s.pose_y = 32'sh80000000; s.heading = 16'sh0000;
    send_sample(s);
    for (int i = 0; i < 8; i++) begin
      s.pose_x = (i & 1) ? 32'sh80000000 : 32'sh7FFFFFFF;
      s.pose_y = (i & 2) ? 32'sh80000000 : 32'sh7FFFFFFF;
      s.heading = hd[i];
      send_sample(s);
    end
    s = '0;
    s.pose_x = 32'sh7FFFFFFF; s.pose_y = 32'sh80000000;
    send_sample(s);
    drain();

    // Zero denominator: no shaping term and a sample exactly at the target.
    write_reg(CFG_INVERSE_SHAPING, 32'd0);
    write_reg(CFG_OFFSET_D, 32'd0);
    write_reg(CFG_TARGET_X, 32'd0);
    write_reg(CFG_TARGET_Y, 32'd0);
    s.pose_x = 32'sh7FFFFFFF; s.pose_y = 32'sh80000000; s.heading = 16'sh0000;
    send_sample(s);
    s.heading = 16'sh8000;
    send_sample(s);
    drain();

    // Huge gains with far targets drive the products into saturation.
    write_reg(CFG_GAIN_LINEAR, 32'h7FFFFFFF);
    write_reg(CFG_GAIN_LATERAL, 32'h7FFFFFFF);
    write_reg(CFG_INVERSE_SHAPING, 32'd1);
    write_reg(CFG_OFFSET_D, 32'h7FFFFFFF);
    write_reg(CFG_TARGET_X, 32'h80000000);
    write_reg(CFG_TARGET_Y, 32'h7FFFFFFF);
    for (int i = 0; i < 6; i++) send_sample(rand_sample(0));
    drain();

    // Random phases, each with a fresh register setting.
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(CFG_TARGET_X, pick32(32'hFFFFFFFF));
      write_reg(CFG_TARGET_Y, pick32(32'hFFFFFFFF));
      write_reg(CFG_GAIN_LINEAR, pick32(32'h7FFFFFFF));
      write_reg(CFG_GAIN_LATERAL, pick32(32'h7FFFFFFF));
      write_reg(CFG_INVERSE_SHAPING, pick32(32'h7FFFFFFF) | 32'd1);
      write_reg(CFG_OFFSET_D, pick32(32'h7FFFFFFF));
      if (ph == 3) hold_cycles = 400;
      random_burst(140);
      if (ph == 5) drain();
      else if (ph != 9) drain();
    end
    drain();

    $display("Sent %0d pose samples over 13 register settings; %0d commands checked.",
             sample_count, cmd_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
